// ===== src/tbxr_pkg.sv =====
package tbxr_pkg;

    localparam int RING_DEPTH = 256;
    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int WIN_W = 9;
    localparam int SEC_W = 35;
    localparam int TS_W = 64;
    localparam int XID_W = 32;
    localparam logic [29:0] ONE_SEC_NS = 30'd1000000000;
    // floor(2^61 / 1e9), applied to timestamp >> 29
    localparam logic [31:0] DIV_RECIP = 32'd2305843009;
    localparam logic [XID_W-1:0] INVALID_XID = '0;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 9'd256;

    typedef enum logic [1:0] {
        ACT_RECORD = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_FILL   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_RECORDED = 3'd0,
        ST_SKIPPED  = 3'd1,
        ST_HIT      = 3'd2,
        ST_AHEAD    = 3'd3,
        ST_TOO_OLD  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_MODS, S_MODH, S_RDH, S_WRH, S_GAP,
        S_RDN, S_RDL, S_OUT
    } fsm_t;

    typedef enum logic [2:0] {
        PH_MUL0, PH_MUL1, PH_MUL2, PH_SUB, PH_FIX
    } div_phase_t;

    typedef struct packed {
        logic         start;
        logic [TS_W-1:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [TS_W-1:0]  quot;
    } div_rsp_t;

endpackage

// ===== src/tbxr_div.sv =====
module tbxr_div import tbxr_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);
    // divide by one billion: reciprocal multiply on ts >> 29 gives an
    // estimate at most three low, then compare-and-subtract fixes it up
    logic [TS_W-1:0]  ts_reg, ts_next;
    logic [TS_W-1:0]  prod_reg, prod_next;
    logic [SEC_W-1:0] q_reg, q_next;
    logic [TS_W-1:0]  r_reg, r_next;
    div_phase_t       ph_reg, ph_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [31:0]      hi_prod;

    always_comb begin
        ts_next   = ts_reg;
        prod_next = prod_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        ph_next   = ph_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        // upper quotient bits times 1e9, only the part below bit 64 matters
        hi_prod   = {29'd0, q_reg[SEC_W-1:32]} * {2'd0, ONE_SEC_NS};
        if (req.start) begin
            ts_next   = req.dividend;
            ph_next   = PH_MUL0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            unique case (ph_reg)
                PH_MUL0: begin
                    prod_next = {32'd0, ts_reg[60:29]} * {32'd0, DIV_RECIP};
                    ph_next = PH_MUL1;
                end
                PH_MUL1: begin
                    q_next = {3'd0, prod_reg[63:32]}
                           + {32'd0, ts_reg[63:61]} * {3'd0, DIV_RECIP};
                    ph_next = PH_MUL2;
                end
                PH_MUL2: begin
                    prod_next = {32'd0, q_reg[31:0]} * {34'd0, ONE_SEC_NS};
                    ph_next = PH_SUB;
                end
                PH_SUB: begin
                    r_next = ts_reg - prod_reg - {hi_prod, 32'd0};
                    ph_next = PH_FIX;
                end
                PH_FIX: begin
                    if (r_reg >= {34'd0, ONE_SEC_NS}) begin
                        r_next = r_reg - {34'd0, ONE_SEC_NS};
                        q_next = q_reg + 35'd1;
                    end else begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default: ph_next = PH_MUL0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ph_reg   <= PH_MUL0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ph_reg   <= ph_next;
        end
        ts_reg   <= ts_next;
        prod_reg <= prod_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = {{(TS_W-SEC_W){1'b0}}, q_reg};

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("divider done while busy");
    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg && !req.start |=> !busy_reg) else $error("divider started by itself");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg) else $error("divider did not start");
`endif
endmodule

// ===== src/tbxr_ram.sv =====
module tbxr_ram import tbxr_pkg::*; (
    input  logic             aclk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [XID_W-1:0] wdata,
    input  logic [IDX_W-1:0] raddr,
    output logic [XID_W-1:0] rdata
);
    logic [XID_W-1:0] mem [RING_DEPTH];
    logic [XID_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== src/time_bucketed_xmin_ring_core.sv =====
// Time-bucketed xmin ring.
// s_axis: one beat per request. tuser = action (0 record, 1 lookup, 2 fill),
// tdata = timestamp_ns in [63:0], xid_value in [95:64]. One m_axis beat
// answers every request: tdata = xid_result, tuser = status.
// cfg_we/cfg_wdata write window_seconds; write it only while idle.
// Record and lookup divide by 1e9 with a reciprocal multiply and a short
// fix-up, take the second modulo the window bit-serially and the head
// modulo the window, then read the ring. A record also fills each skipped
// second (capped by the window); a fill writes all 256 ring entries.
// One request is in flight at a time; the next beat can be taken in the
// cycle after the result beat is taken.
// All ring traffic goes through one RAM with one write and one read port
// and a registered read. After reset the ring is cleared, all 256 entries;
// s_axis_tready is low then. The result sits in an output register; while
// m_axis_tready is low no new request is taken, and the beat holds until taken.
module time_bucketed_xmin_ring_core import tbxr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // timestamp_ns[63:0], xid_value[95:64]
    input  logic [1:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // xid_result
    output logic [2:0]  m_axis_tuser,   // status
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata       // window_seconds
);
    fsm_t state_reg, state_next;
    logic [WIN_W-1:0] win_reg;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [SEC_W-1:0] last_reg, last_next;
    logic [1:0]       act_reg, act_next;
    logic [XID_W-1:0] xid_reg, xid_next;
    logic [TS_W-1:0]  ts_reg, ts_next;
    logic [SEC_W-1:0] sec_reg, sec_next;
    // bit-serial modulo working set
    logic [SEC_W-1:0] md_reg, md_next;
    logic [WIN_W:0]   rem_reg, rem_next;
    logic [5:0]       mcnt_reg, mcnt_next;
    logic [IDX_W-1:0] off_reg, off_next;
    logic [IDX_W-1:0] hmod_reg, hmod_next;
    logic [WIN_W-1:0] gcnt_reg, gcnt_next;
    logic [XID_W-1:0] prev_reg, prev_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic             ov_reg, ov_next;
    logic [XID_W-1:0] or_reg, or_next;
    status_t          os_reg, os_next;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    logic [XID_W-1:0] wdata, rdata;
    div_req_t         dreq;
    div_rsp_t         drsp;
    logic [WIN_W-1:0] w_eff;
    logic [WIN_W:0]   rtrial;
    logic [SEC_W-1:0] gap;
    logic [IDX_W:0]   nxt;

    always_comb begin
        w_eff = win_reg;
        if (win_reg == '0) w_eff = 9'd1;
        if (win_reg > 9'(RING_DEPTH)) w_eff = 9'(RING_DEPTH);
    end

    tbxr_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));
    tbxr_ram u_ram (.aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
                    .raddr(raddr), .rdata(rdata));

    assign s_axis_tready = (state_reg == S_IDLE) && !ov_reg;

    always_comb begin
        state_next = state_reg;
        head_next = head_reg; last_next = last_reg; act_next = act_reg;
        xid_next = xid_reg; ts_next = ts_reg; sec_next = sec_reg;
        md_next = md_reg; rem_next = rem_reg; mcnt_next = mcnt_reg;
        off_next = off_reg; hmod_next = hmod_reg; gcnt_next = gcnt_reg;
        prev_next = prev_reg; clr_next = clr_reg;
        ov_next = ov_reg; or_next = or_reg; os_next = os_reg;
        we = 1'b0; waddr = off_reg; wdata = xid_reg; raddr = hmod_reg;
        dreq.start = 1'b0; dreq.dividend = ts_reg;
        rtrial = {rem_reg[WIN_W-1:0], md_reg[SEC_W-1]};
        gap = sec_reg - last_reg;
        nxt = {1'b0, off_reg} + 9'd1;
        if (ov_reg && m_axis_tready) ov_next = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                we = 1'b1; waddr = clr_reg;
                wdata = (act_reg == ACT_FILL) ? xid_reg : INVALID_XID;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(RING_DEPTH - 1)) begin
                    if (act_reg == ACT_FILL) begin
                        or_next = xid_reg; os_next = ST_RECORDED; ov_next = 1'b1;
                    end
                    act_next = ACT_NONE;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    act_next = s_axis_tuser;
                    ts_next = s_axis_tdata[63:0];
                    xid_next = s_axis_tdata[95:64];
                    unique case (action_t'(s_axis_tuser))
                        ACT_RECORD, ACT_LOOKUP: begin
                            dreq.start = 1'b1; dreq.dividend = s_axis_tdata[63:0];
                            state_next = S_DIV;
                        end
                        ACT_FILL: begin
                            clr_next = '0; state_next = S_CLEAR;
                        end
                        default: begin
                            or_next = INVALID_XID; os_next = ST_SKIPPED; ov_next = 1'b1;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (drsp.done) begin
                    if (act_reg == ACT_RECORD) begin
                        sec_next = drsp.quot[SEC_W-1:0] + 35'd1;
                        if (drsp.quot[SEC_W-1:0] + 35'd1 > last_reg) begin
                            md_next = drsp.quot[SEC_W-1:0] + 35'd1;
                            rem_next = '0; mcnt_next = 6'(SEC_W);
                            state_next = S_MODS;
                        end else begin
                            or_next = INVALID_XID; os_next = ST_SKIPPED;
                            ov_next = 1'b1; state_next = S_IDLE;
                        end
                    end else begin
                        sec_next = drsp.quot[SEC_W-1:0];
                        md_next = drsp.quot[SEC_W-1:0];
                        rem_next = '0; mcnt_next = 6'(SEC_W);
                        state_next = S_MODS;
                    end
                end
            end
            S_MODS: begin
                if (rtrial >= {1'b0, w_eff}) rem_next = rtrial - {1'b0, w_eff};
                else rem_next = rtrial;
                md_next = {md_reg[SEC_W-2:0], 1'b0};
                mcnt_next = mcnt_reg - 6'd1;
                if (mcnt_reg == 6'd1) begin
                    md_next = {{(SEC_W-IDX_W){1'b0}}, head_reg} << (SEC_W - IDX_W);
                    mcnt_next = 6'(IDX_W);
                    state_next = S_MODH;
                end
            end
            S_MODH: begin
                if (mcnt_reg == 6'(IDX_W)) off_next = rem_reg[IDX_W-1:0];
                if (mcnt_reg == 6'(IDX_W)) rtrial = {9'd0, md_reg[SEC_W-1]};
                if (rtrial >= {1'b0, w_eff}) rem_next = rtrial - {1'b0, w_eff};
                else rem_next = rtrial;
                md_next = {md_reg[SEC_W-2:0], 1'b0};
                mcnt_next = mcnt_reg - 6'd1;
                if (mcnt_reg == 6'd1) state_next = S_RDH;
            end
            S_RDH: begin
                hmod_next = rem_reg[IDX_W-1:0];
                raddr = rem_reg[IDX_W-1:0];
                if (act_reg == ACT_RECORD) begin
                    state_next = S_WRH;
                end else if (sec_reg > last_reg) begin
                    os_next = ST_AHEAD; state_next = S_OUT;
                end else if (last_reg - sec_reg < {26'd0, w_eff}) begin
                    raddr = off_reg; os_next = ST_HIT; state_next = S_OUT;
                end else begin
                    or_next = INVALID_XID; os_next = ST_TOO_OLD;
                    ov_next = 1'b1; state_next = S_IDLE;
                end
            end
            S_WRH: begin
                prev_next = rdata;
                we = 1'b1; waddr = off_reg; wdata = xid_reg;
                head_next = off_reg;
                last_next = sec_reg;
                hmod_next = off_reg;
                gcnt_next = (gap > {26'd0, w_eff}) ? w_eff : gap[WIN_W-1:0];
                state_next = S_GAP;
            end
            S_GAP: begin
                if (gcnt_reg <= 9'd1) begin
                    state_next = S_RDN;
                end else begin
                    off_next = (off_reg == '0) ? IDX_W'(w_eff - 9'd1) : off_reg - 1'b1;
                    we = 1'b1;
                    waddr = (off_reg == '0) ? IDX_W'(w_eff - 9'd1) : off_reg - 1'b1;
                    wdata = prev_reg;
                    gcnt_next = gcnt_reg - 9'd1;
                end
            end
            S_RDN: begin
                nxt = {1'b0, hmod_reg} + 9'd1;
                raddr = (nxt == w_eff) ? '0 : nxt[IDX_W-1:0];
                os_next = ST_RECORDED;
                state_next = S_OUT;
            end
            S_OUT: begin
                or_next = rdata; ov_next = 1'b1; state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            win_reg <= WINDOW_RESET;
            head_reg <= '0; last_reg <= '0; clr_reg <= '0;
            ov_reg <= 1'b0; act_reg <= ACT_NONE;
        end else begin
            state_reg <= state_next;
            if (cfg_we) win_reg <= cfg_wdata;
            head_reg <= head_next; last_reg <= last_next; clr_reg <= clr_next;
            ov_reg <= ov_next; act_reg <= act_next;
        end
        xid_reg <= xid_next; ts_reg <= ts_next; sec_reg <= sec_next;
        md_reg <= md_next; rem_reg <= rem_next; mcnt_reg <= mcnt_next;
        off_reg <= off_next; hmod_reg <= hmod_next; gcnt_reg <= gcnt_next;
        prev_reg <= prev_next; or_reg <= or_next; os_reg <= os_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = or_reg;
    assign m_axis_tuser  = os_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> state_reg == S_IDLE && !ov_reg) else $error("accept while busy");
    a_head_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WRH |-> {1'b0, off_reg} < w_eff) else $error("head beyond window");
    a_last_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_CLEAR && $past(state_reg) != S_CLEAR |-> last_reg >= $past(last_reg))
        else $error("last second went back");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_div_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        drsp.busy |-> state_reg == S_DIV) else $error("divider busy outside divide step");
`endif
endmodule
